// File: rtl/sswq_pkg.sv
// ----------------------------------------------------------------------------
// sswq_pkg
// shared types and constants of the sequenced slot window queue
// ----------------------------------------------------------------------------
`default_nettype none

package sswq_pkg;

  localparam int CAPACITY_BITS = 8;
  localparam int SEQ_BITS      = 16;
  localparam int RING_DEPTH    = 1 << CAPACITY_BITS;
  localparam int SLOT_BITS     = 3;
  localparam int COUNT_BITS    = 8;

  typedef logic [SEQ_BITS-1:0]      seq_t;
  typedef logic [CAPACITY_BITS-1:0] slot_idx_t;
  typedef logic [COUNT_BITS-1:0]    count_t;

  // slot life cycle
  typedef enum logic [SLOT_BITS-1:0] {
    SLOT_FREE  = 3'd0,
    SLOT_ALLOC = 3'd1,
    SLOT_READY = 3'd2,
    SLOT_PROC  = 3'd3,
    SLOT_ACKED = 3'd4,
    SLOT_PFREE = 3'd5
  } slot_state_t;

  // operation codes
  typedef enum logic [2:0] {
    FN_ALLOC_TAIL = 3'd0,
    FN_ALLOC_SEQ  = 3'd1,
    FN_READY      = 3'd2,
    FN_PROC       = 3'd3,
    FN_ACKED      = 3'd4,
    FN_RELEASE    = 3'd5,
    FN_COLLECT    = 3'd6,
    FN_FIND       = 3'd7
  } func_t;

  typedef struct packed {
    logic   ok;
    seq_t   seq_out;
    count_t collected;
    seq_t   head_seq;
    seq_t   tail_seq;
  } result_t;

  // slot memory port
  typedef struct packed {
    logic                 we;
    slot_idx_t            waddr;
    logic [SLOT_BITS-1:0] wdata;
    logic                 re;
    slot_idx_t            raddr;
  } ram_cmd_t;

endpackage

`default_nettype wire

// File: rtl/sswq_req_if.sv
// ----------------------------------------------------------------------------
// sswq_req_if
// request channel: operation code and addressed sequence number
// ----------------------------------------------------------------------------
`default_nettype none

interface sswq_req_if import sswq_pkg::*; ();

  logic       valid;
  logic       ready;
  logic [2:0] func;
  seq_t       seq;

  modport source (output valid, func, seq, input ready);
  modport sink (input valid, func, seq, output ready);

endinterface

`default_nettype wire

// File: rtl/sswq_rsp_if.sv
// ----------------------------------------------------------------------------
// sswq_rsp_if
// response channel: status, sequence numbers and collect count
// ----------------------------------------------------------------------------
`default_nettype none

interface sswq_rsp_if import sswq_pkg::*; ();

  logic   valid;
  logic   ready;
  logic   ok;
  seq_t   seq_out;
  count_t collected;
  seq_t   head_seq;
  seq_t   tail_seq;

  modport source (output valid, ok, seq_out, collected, head_seq, tail_seq, input ready);
  modport sink (input valid, ok, seq_out, collected, head_seq, tail_seq, output ready);

endinterface

`default_nettype wire

// File: rtl/sswq_ram.sv
// ----------------------------------------------------------------------------
// sswq_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module sswq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/sswq_engine.sv
// ----------------------------------------------------------------------------
// sswq_engine
// read-modify-write sequencer over the slot memory, head and tail counters
// ----------------------------------------------------------------------------
`default_nettype none

module sswq_engine import sswq_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  sswq_req_if.sink                  req,
  output ram_cmd_t                  ram,
  input  wire logic [SLOT_BITS-1:0] ram_rdata,
  output logic                      res_valid,
  output result_t                   res,
  input  wire logic                 res_ready
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_WALK
  } state_t;

  state_t    state, state_next;
  slot_idx_t clr_idx;
  func_t     func_q;
  seq_t      seq_q;
  seq_t      head, head_next;
  seq_t      tail, tail_next;
  count_t    n_coll, n_coll_next;

  logic        accept;
  func_t       req_func;
  slot_state_t slot;
  seq_t        new_tail, new_cnt, old_cnt, offset;
  logic        in_reach;
  logic        exec_ok;
  logic        exec_wr;
  slot_state_t exec_wdata;
  logic        walk_go;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign req_func  = func_t'(req.func);
  assign slot      = slot_state_t'(ram_rdata);

  // window arithmetic, all modulo the sequence space
  assign new_tail = seq_q + seq_t'(1);
  assign new_cnt  = new_tail - head;
  assign old_cnt  = tail - head;
  assign offset   = seq_q - head;
  assign in_reach = 32'(new_cnt) < 32'(RING_DEPTH);

  always_comb begin
    exec_ok    = 1'b0;
    exec_wr    = 1'b0;
    exec_wdata = SLOT_FREE;
    case (func_q)
      FN_ALLOC_TAIL, FN_ALLOC_SEQ: begin
        exec_ok    = in_reach && (slot == SLOT_FREE);
        exec_wr    = exec_ok;
        exec_wdata = SLOT_ALLOC;
      end
      FN_READY: begin
        exec_ok    = (slot == SLOT_ALLOC);
        exec_wr    = exec_ok;
        exec_wdata = SLOT_READY;
      end
      FN_PROC: begin
        exec_ok    = (slot == SLOT_READY);
        exec_wr    = exec_ok;
        exec_wdata = SLOT_PROC;
      end
      FN_ACKED: begin
        exec_ok    = (slot == SLOT_PROC);
        exec_wr    = exec_ok;
        exec_wdata = SLOT_ACKED;
      end
      FN_RELEASE: begin
        exec_ok    = (slot != SLOT_FREE);
        exec_wr    = exec_ok;
        exec_wdata = SLOT_PFREE;
      end
      FN_FIND: begin
        exec_ok = offset < old_cnt;
      end
      default: begin
        exec_ok = 1'b0;
      end
    endcase
  end

  // collect keeps going while the head slot is pending-free and the window is not empty
  assign walk_go = (state == ST_WALK) && (head != tail) && (slot == SLOT_PFREE);

  always_comb begin
    state_next  = state;
    head_next   = head;
    tail_next   = tail;
    n_coll_next = n_coll;
    ram         = '0;
    res_valid   = 1'b0;
    res         = '0;
    case (state)
      ST_CLEAR: begin
        ram.we    = 1'b1;
        ram.waddr = clr_idx;
        ram.wdata = SLOT_FREE;
        if (clr_idx == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        ram.re = accept;
        case (req_func)
          FN_ALLOC_TAIL: ram.raddr = tail[CAPACITY_BITS-1:0];
          FN_COLLECT:    ram.raddr = head[CAPACITY_BITS-1:0];
          default:       ram.raddr = req.seq[CAPACITY_BITS-1:0];
        endcase
        if (accept) begin
          n_coll_next = '0;
          state_next  = (req_func == FN_COLLECT) ? ST_WALK : ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_valid = 1'b1;
        if (exec_ok && (func_q == FN_ALLOC_TAIL || func_q == FN_ALLOC_SEQ) &&
            new_cnt > old_cnt) begin
          tail_next = new_tail;
        end
        res.ok        = exec_ok;
        res.seq_out   = seq_q;
        res.collected = '0;
        res.head_seq  = head;
        res.tail_seq  = tail_next;
        if (res_ready) begin
          ram.we     = exec_wr;
          ram.waddr  = seq_q[CAPACITY_BITS-1:0];
          ram.wdata  = exec_wdata;
          state_next = ST_IDLE;
        end else begin
          tail_next = tail;
        end
      end
      ST_WALK: begin
        if (walk_go) begin
          ram.we      = 1'b1;
          ram.waddr   = head[CAPACITY_BITS-1:0];
          ram.wdata   = SLOT_FREE;
          head_next   = head + seq_t'(1);
          ram.re      = 1'b1;
          ram.raddr   = head_next[CAPACITY_BITS-1:0];
          n_coll_next = (n_coll == '1) ? n_coll : n_coll + count_t'(1);
        end else begin
          res_valid     = 1'b1;
          res.ok        = (n_coll != '0);
          res.seq_out   = '0;
          res.collected = n_coll;
          res.head_seq  = head;
          res.tail_seq  = tail;
          if (res_ready) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
      head    <= '0;
      tail    <= '0;
      n_coll  <= '0;
    end else begin
      state   <= state_next;
      clr_idx <= clr_idx + slot_idx_t'(1);
      head    <= head_next;
      tail    <= tail_next;
      n_coll  <= n_coll_next;
    end
  end

  // item registers
  always_ff @(posedge clk) begin
    if (accept) begin
      func_q <= req_func;
      seq_q  <= (req_func == FN_ALLOC_TAIL) ? tail : req.seq;
    end
  end

  a_window_bound: assert property (@(posedge clk) disable iff (rst)
    32'(old_cnt) < 32'(RING_DEPTH))
    else $error("window wider than the ring");

  a_head_only_in_walk: assert property (@(posedge clk) disable iff (rst)
    (state != ST_WALK) |=> (head == $past(head)))
    else $error("head moved outside collect");

  a_tail_only_in_exec: assert property (@(posedge clk) disable iff (rst)
    (state != ST_EXEC) |=> (tail == $past(tail)))
    else $error("tail moved outside an allocation");

  a_accept_starts_work: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_EXEC || state == ST_WALK))
    else $error("accepted transaction not started");

endmodule

`default_nettype wire

// File: rtl/sequenced_slot_window_queue.sv
// ----------------------------------------------------------------------------
// sequenced_slot_window_queue
// sliding window of sequence-numbered slots with a life-cycle state per slot
// ----------------------------------------------------------------------------
// sequence: a request's slot is read from the slot memory's single read port in
//   the idle state, checked and written back in the exec state, and the result
//   is held in the response register; collect walks one slot per cycle in the
//   walk state. A new request is taken only once the previous one has committed
// reset: synchronous; head and tail go to 0, then a clearing pass writes all
//   RING_DEPTH (256) slots free before the first request is taken
// ----------------------------------------------------------------------------
`default_nettype none

module sequenced_slot_window_queue import sswq_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  sswq_req_if.sink    req,
  sswq_rsp_if.source  rsp
);

  ram_cmd_t             ram;
  logic [SLOT_BITS-1:0] ram_rdata;
  logic                 res_valid;
  logic                 res_ready;
  result_t              res;

  // slot life-cycle store, one entry per ring position
  sswq_ram #(
    .WIDTH (SLOT_BITS),
    .DEPTH (RING_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram.we),
    .waddr (ram.waddr),
    .wdata (ram.wdata),
    .re    (ram.re),
    .raddr (ram.raddr),
    .rdata (ram_rdata)
  );

  // sequencer: decodes the transaction, updates the slot and the counters
  sswq_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .ram       (ram),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  // response register: the engine commits only when this stage can take
  // the result, so a stalled response never holds up the slot memory
  // beyond the transaction in flight
  assign res_ready = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_ready) begin
      rsp.valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp.ok        <= res.ok;
      rsp.seq_out   <= res.seq_out;
      rsp.collected <= res.collected;
      rsp.head_seq  <= res.head_seq;
      rsp.tail_seq  <= res.tail_seq;
    end
  end

endmodule

`default_nettype wire

// File: bench/sswq_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sswq_checker
// watches both channels, predicts every response and compares it in order
// ----------------------------------------------------------------------------
`default_nettype none

module sswq_checker import sswq_pkg::*; (
  input  wire logic                               clk,
  input  wire logic                               rst,
  sswq_req_if                                     req,
  sswq_rsp_if                                     rsp,
  output int                                      fail_count,
  output int                                      outstanding,
  output seq_t                                    win_head,
  output seq_t                                    win_tail,
  output logic [RING_DEPTH-1:0][SLOT_BITS-1:0]    slot_map
);

  // shadow of the window
  slot_state_t ring [RING_DEPTH];
  seq_t        head_q;
  seq_t        tail_q;

  result_t     due_rsp [$];
  result_t     got;
  result_t     want;
  int          errors = 0;

  function automatic bit step_slot(seq_t s, slot_state_t from, slot_state_t to);
    slot_idx_t idx;
    idx = s[CAPACITY_BITS-1:0];
    if (ring[idx] != from) return 1'b0;
    ring[idx] = to;
    return 1'b1;
  endfunction

  function automatic bit try_alloc(seq_t target);
    seq_t next_tail;
    seq_t span_new;
    seq_t span_old;
    next_tail = target + 16'd1;
    span_new  = next_tail - head_q;
    span_old  = tail_q - head_q;
    if (span_new >= RING_DEPTH) return 1'b0;
    if (!step_slot(target, SLOT_FREE, SLOT_ALLOC)) return 1'b0;
    if (span_new > span_old) tail_q = next_tail;
    return 1'b1;
  endfunction

  function automatic result_t window_op(func_t f, seq_t s);
    result_t r;
    int      freed;
    seq_t    offset;
    seq_t    span;
    r = '0;
    r.seq_out = s;
    case (f)
      FN_ALLOC_TAIL: begin
        r.seq_out = tail_q;
        r.ok      = try_alloc(tail_q);
      end
      FN_ALLOC_SEQ: r.ok = try_alloc(s);
      FN_READY:     r.ok = step_slot(s, SLOT_ALLOC, SLOT_READY);
      FN_PROC:      r.ok = step_slot(s, SLOT_READY, SLOT_PROC);
      FN_ACKED:     r.ok = step_slot(s, SLOT_PROC, SLOT_ACKED);
      FN_RELEASE: begin
        if (ring[s[CAPACITY_BITS-1:0]] != SLOT_FREE) begin
          ring[s[CAPACITY_BITS-1:0]] = SLOT_PFREE;
          r.ok = 1'b1;
        end
      end
      FN_COLLECT: begin
        freed = 0;
        r.seq_out = '0;
        while (head_q != tail_q && ring[head_q[CAPACITY_BITS-1:0]] == SLOT_PFREE) begin
          ring[head_q[CAPACITY_BITS-1:0]] = SLOT_FREE;
          head_q = head_q + 16'd1;
          freed++;
        end
        r.collected = (freed > 255) ? count_t'(255) : count_t'(freed);
        r.ok        = (freed != 0);
      end
      default: begin
        offset = s - head_q;
        span   = tail_q - head_q;
        r.ok   = (offset < span);
      end
    endcase
    r.head_seq = head_q;
    r.tail_seq = tail_q;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      foreach (ring[i]) ring[i] = SLOT_FREE;
      head_q = '0;
      tail_q = '0;
      due_rsp.delete();
    end else begin
      // responses first: one taken at this edge belongs to an older request
      if (rsp.valid && rsp.ready) begin
        got.ok        = rsp.ok;
        got.seq_out   = rsp.seq_out;
        got.collected = rsp.collected;
        got.head_seq  = rsp.head_seq;
        got.tail_seq  = rsp.tail_seq;
        if (due_rsp.size() == 0) begin
          $display("%0t: unexpected response ok=%0b seq_out=%h collected=%0d head=%h tail=%h",
                   $time, got.ok, got.seq_out, got.collected, got.head_seq, got.tail_seq);
          errors++;
        end else begin
          want = due_rsp.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected ok=%0b seq_out=%h collected=%0d head=%h tail=%h",
                     $time, want.ok, want.seq_out, want.collected, want.head_seq,
                     want.tail_seq);
            $display("%0t:          actual   ok=%0b seq_out=%h collected=%0d head=%h tail=%h",
                     $time, got.ok, got.seq_out, got.collected, got.head_seq, got.tail_seq);
            errors++;
          end
        end
      end
      if (req.valid && req.ready)
        due_rsp.push_back(window_op(func_t'(req.func), req.seq));
    end
    fail_count  <= errors;
    outstanding <= due_rsp.size();
    win_head    <= head_q;
    win_tail    <= tail_q;
    for (int i = 0; i < RING_DEPTH; i++) slot_map[i] <= ring[i];
  end

endmodule

`default_nettype wire

// File: bench/tb_sequenced_slot_window_queue.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sequenced_slot_window_queue
// drives operations on the slot window with random gaps and stalls; the
// checker alongside predicts each response and counts mismatches
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sequenced_slot_window_queue;
  import sswq_pkg::*;

  // generous ceiling: ~800 transactions at worst-case gaps, stalls and sweeps
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 200;

  logic clk;
  logic rst;

  sswq_req_if req ();
  sswq_rsp_if rsp ();

  int   fail_count;
  int   outstanding;
  seq_t win_head;
  seq_t win_tail;
  logic [RING_DEPTH-1:0][SLOT_BITS-1:0] slot_map;

  // zero-gap stretches on both sides when set
  bit   steady = 1'b0;
  // cycles the response side holds off before its next transaction
  int   rsp_hold = 0;
  int   cycle_count = 0;

  sequenced_slot_window_queue DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  sswq_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .win_head    (win_head),
    .win_tail    (win_tail),
    .slot_map    (slot_map)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run guard, also covers the clearing pass after reset
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // offer one request after a random gap, return once it is taken
  task automatic issue(input func_t f, input seq_t s);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.func  <= f;
    req.seq   <= s;
    do @(posedge clk); while (!req.ready);
  endtask

  // stop offering and wait for every outstanding response
  task automatic drain();
    req.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // mostly well-formed slot life cycles, plus aliased, out-of-window and
  // wrong-order requests and plain noise
  task automatic random_op();
    int          r;
    int          span;
    int          reach;
    seq_t        s;
    func_t       f;
    slot_state_t st;
    span = int'(seq_t'(win_tail - win_head));
    r    = $urandom_range(0, 99);
    s    = seq_t'($urandom);
    if (r < 10) begin
      f = func_t'($urandom_range(0, 7));
    end else if (r < 30) begin
      f = FN_ALLOC_TAIL;
    end else if (r < 36) begin
      f = FN_ALLOC_SEQ;
      s = seq_t'(win_head + $urandom_range(0, 270));
    end else if (r < 42) begin
      f = FN_FIND;
      s = seq_t'(win_head + $urandom_range(0, span + 4) - 2);
    end else if (r < 50) begin
      f = FN_COLLECT;
    end else if (r < 56) begin
      // step taken regardless of the slot's present state
      f = func_t'($urandom_range(FN_READY, FN_RELEASE));
      s = seq_t'(win_head + $urandom_range(0, span));
    end else if (span == 0) begin
      f = FN_ALLOC_TAIL;
    end else begin
      // half the time stay near the head so collects make progress
      reach = ($urandom_range(0, 1) == 1 && span > 8) ? 7 : span - 1;
      s  = seq_t'(win_head + $urandom_range(0, reach));
      st = slot_state_t'(slot_map[s[CAPACITY_BITS-1:0]]);
      case (st)
        SLOT_FREE:  f = FN_ALLOC_SEQ;
        SLOT_ALLOC: f = FN_READY;
        SLOT_READY: f = FN_PROC;
        SLOT_PROC:  f = FN_ACKED;
        SLOT_ACKED: f = FN_RELEASE;
        default:    f = FN_COLLECT;
      endcase
    end
    issue(f, s);
  endtask

  // response side: random stalls, zero-stall stretches and one long hold-off
  initial begin : response_side
    int stall;
    rsp.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (rsp_hold > 0) begin
        stall    = rsp_hold;
        rsp_hold = 0;
      end else begin
        stall = steady ? 0 : $urandom_range(0, 6);
      end
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
    end
  end

  initial begin : stimulus
    seq_t base;
    int   span;
    seq_t slot_seq;
    rst = 1'b1;
    req.valid <= 1'b0;
    req.func  <= FN_FIND;
    req.seq   <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: empty window, one full life cycle, wrong predecessors,
    // slot aliasing, window reach limits and collect stopping at a free slot
    issue(FN_FIND,       16'h0000);   // empty window, miss
    issue(FN_COLLECT,    16'hFFFF);   // nothing pending free
    issue(FN_ALLOC_TAIL, 16'h5A5A);   // seq ignored, takes 0
    issue(FN_ALLOC_TAIL, 16'h0000);   // takes 1
    issue(FN_READY,      16'h0000);
    issue(FN_PROC,       16'h0000);
    issue(FN_ACKED,      16'h0000);
    issue(FN_READY,      16'h0000);   // acked slot cannot go back to ready
    issue(FN_PROC,       16'h0001);   // allocated, not yet ready
    issue(FN_ACKED,      16'h0101);   // aliases slot 1, wrong state
    issue(FN_RELEASE,    16'h0000);
    issue(FN_RELEASE,    16'h0000);   // already pending free, still ok
    issue(FN_RELEASE,    16'h0005);   // free slot refused
    issue(FN_ALLOC_SEQ,  16'h00FF);   // one beyond window reach
    issue(FN_ALLOC_SEQ,  16'h00FE);   // furthest reach, tail jumps
    issue(FN_ALLOC_SEQ,  16'h00FE);   // slot taken
    issue(FN_ALLOC_SEQ,  16'hFFFF);   // behind the head, wraps into reach
    issue(FN_READY,      16'hFF00);   // aliases slot 0, pending free
    issue(FN_FIND,       16'hFFFF);
    issue(FN_FIND,       16'h00FE);
    issue(FN_FIND,       16'h00FF);   // just past the tail
    issue(FN_COLLECT,    16'h0000);   // frees slot 0, stops at allocated slot 1
    issue(FN_RELEASE,    16'h0001);
    issue(FN_COLLECT,    16'h1234);   // frees slot 1, stops at free slot 2
    issue(FN_ALLOC_TAIL, 16'h0000);   // tail slot already taken by the wrap

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 50 == 0) steady = ($urandom_range(0, 3) == 0);
      if (i == 100) begin
        // pause until all responses are back, then stall the response side
        // for a long stretch while requests keep coming back to back
        drain();
        rsp_hold = 160;
        steady   = 1'b1;
      end
      if (i == 150) steady = 1'b0;
      random_op();
    end

    // saturating collect: occupy every free slot in the window, grow it to
    // capacity, release every slot and sweep them all in one collect
    steady = 1'b0;
    drain();
    base = win_head;
    span = int'(seq_t'(win_tail - win_head));
    for (int k = 0; k < span; k++) begin
      slot_seq = seq_t'(base + k);
      if (slot_map[slot_seq[CAPACITY_BITS-1:0]] == SLOT_FREE) issue(FN_ALLOC_SEQ, slot_seq);
    end
    // the last allocation is refused, the window being full
    for (int k = span; k < RING_DEPTH; k++) issue(FN_ALLOC_TAIL, seq_t'($urandom));
    for (int k = 0; k < RING_DEPTH - 1; k++) issue(FN_RELEASE, seq_t'(base + k));
    issue(FN_COLLECT, seq_t'($urandom));

    for (int i = 0; i < 40; i++) random_op();

    // wait out every response, then a quiet tail to catch strays
    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
